@@ sv/ckp_pkg.sv @@
// Shared types and constants for the complex Kronecker product block.
`default_nettype none

package ckp_pkg;

    localparam int MAX_B_ENTRIES = 64;
    localparam int BIDX_W        = $clog2(MAX_B_ENTRIES);
    localparam int BCNT_W        = BIDX_W + 1;
    localparam int BQ_W          = 3;
    localparam int VAL_W         = 16;
    localparam int PP_W          = 2 * VAL_W;
    localparam int PROD_W        = PP_W + 1;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MUL  = 1'b1;

    typedef struct packed {
        logic                    is_mul;
        logic [BIDX_W-1:0]       idx;
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } ckp_item_t;

    typedef struct packed {
        logic busy;
        logic issue_last;
    } ckp_status_t;

endpackage

`default_nettype wire

@@ sv/complex_kronecker_product.sv @@
// Top level of the complex Kronecker product block.
//
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall  cmd, b_index, val_re, val_im
//  out      out  out_valid/out_stall  prod_re, prod_im, out_b_index, last
//  cfg      in   cfg_wr_en            cfg_wr_data (b_qubits)
//
// A load word is one store write; a multiply word sweeps 2^b_qubits entries
// (at most 64), one product per cycle unless the output stalls, set by the
// single store read port feeding one complex multiplier via the read
// register and both multiplier stages. A four-word input queue lets the
// input side keep accepting while the sweep runs or the output stalls.
// Reset clears control state; store contents are undefined until loaded.
`default_nettype none

module complex_kronecker_product (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wr_en,
    input  wire  [ckp_pkg::BQ_W-1:0]           cfg_wr_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                cmd,
    input  wire  [ckp_pkg::BIDX_W-1:0]         b_index,
    input  wire  signed [ckp_pkg::VAL_W-1:0]   val_re,
    input  wire  signed [ckp_pkg::VAL_W-1:0]   val_im,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [ckp_pkg::PROD_W-1:0] prod_re,
    output logic signed [ckp_pkg::PROD_W-1:0] prod_im,
    output logic [ckp_pkg::BIDX_W-1:0]         out_b_index,
    output logic                               last
);
    import ckp_pkg::*;

    logic [BQ_W-1:0] b_qubits_reg;
    ckp_item_t       q_item;
    logic            q_valid;
    logic            q_pop;
    ckp_status_t     status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_qubits_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            b_qubits_reg <= cfg_wr_data;
        end
    end

    ckp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .b_index  (b_index),
        .val_re   (val_re),
        .val_im   (val_im),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    ckp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .b_qubits    (b_qubits_reg),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .prod_re     (prod_re),
        .prod_im     (prod_im),
        .out_b_index (out_b_index),
        .last        (last)
    );

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !status.busy)
        else $error("queue popped during a sweep");

    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        status.issue_last |=> !status.busy)
        else $error("sweep still busy after its final read");

    a_last_ends_valid: assert property (@(posedge clk) disable iff (!rst_n)
        status.issue_last |-> status.busy)
        else $error("final read issued without an active sweep");
`endif

endmodule

`default_nettype wire

@@ sv/ckp_front.sv @@
// Input side: classify incoming words and hold them in a short queue.
`default_nettype none

module ckp_front (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire                            cmd,
    input  wire  [ckp_pkg::BIDX_W-1:0]     b_index,
    input  wire  signed [ckp_pkg::VAL_W-1:0] val_re,
    input  wire  signed [ckp_pkg::VAL_W-1:0] val_im,
    output ckp_pkg::ckp_item_t             q_item,
    output logic                           q_valid,
    input  wire                            q_pop
);
    import ckp_pkg::*;

    ckp_item_t        queue_mem [QDEPTH];
    ckp_item_t        push_item;
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     cnt_reg, cnt_next;
    logic             push;

    assign in_stall = (cnt_reg == (QAW+1)'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb
    begin
        push_item.is_mul = (cmd == CMD_MUL);
        push_item.idx    = b_index;
        push_item.re     = val_re;
        push_item.im     = val_im;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/ckp_cmul.sv @@
// Two-stage complex multiplier: partial products, then add and subtract.
`default_nettype none

module ckp_cmul (
    input  wire                               clk,
    input  wire                               en,
    input  wire  signed [ckp_pkg::VAL_W-1:0]  a_re,
    input  wire  signed [ckp_pkg::VAL_W-1:0]  a_im,
    input  wire  signed [ckp_pkg::VAL_W-1:0]  b_re,
    input  wire  signed [ckp_pkg::VAL_W-1:0]  b_im,
    output logic signed [ckp_pkg::PROD_W-1:0] p_re,
    output logic signed [ckp_pkg::PROD_W-1:0] p_im
);
    import ckp_pkg::*;

    logic signed [PP_W-1:0]   rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [PROD_W-1:0] p_re_reg, p_im_reg;
    logic signed [PROD_W-1:0] p_re_next, p_im_next;

    // Sign-extend the partial products to the full product width.
    assign p_re_next = PROD_W'(rr_reg) - PROD_W'(ii_reg);
    assign p_im_next = PROD_W'(ri_reg) + PROD_W'(ir_reg);

    assign p_re = p_re_reg;
    assign p_im = p_im_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg   <= a_re * b_re;
            ii_reg   <= a_im * b_im;
            ri_reg   <= a_re * b_im;
            ir_reg   <= a_im * b_re;
            p_re_reg <= p_re_next;
            p_im_reg <= p_im_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ckp_back.sv @@
// Execution side: entry store, index sweep and product pipeline.
`default_nettype none

module ckp_back (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  [ckp_pkg::BQ_W-1:0]          b_qubits,
    input  wire  ckp_pkg::ckp_item_t          q_item,
    input  wire                               q_valid,
    output logic                              q_pop,
    output ckp_pkg::ckp_status_t              status,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic signed [ckp_pkg::PROD_W-1:0] prod_re,
    output logic signed [ckp_pkg::PROD_W-1:0] prod_im,
    output logic [ckp_pkg::BIDX_W-1:0]        out_b_index,
    output logic                              last
);
    import ckp_pkg::*;

    logic signed [VAL_W-1:0] b_mem_re [MAX_B_ENTRIES];
    logic signed [VAL_W-1:0] b_mem_im [MAX_B_ENTRIES];

    logic                    busy_reg, busy_next;
    logic [BIDX_W-1:0]       k_reg, k_next;
    logic [BIDX_W-1:0]       last_k_reg, last_k_next;
    logic [BIDX_W-1:0]       last_k_cfg;
    logic signed [VAL_W-1:0] a_re_reg, a_im_reg;

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [VAL_W-1:0] s1_a_re_reg, s1_a_im_reg;
    logic signed [VAL_W-1:0] s1_b_re_reg, s1_b_im_reg;
    logic [BIDX_W-1:0]       s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic                    s1_last_reg, s2_last_reg, s3_last_reg;

    logic advance, issue, issue_last, start_mul, do_load;

    // Whole pipeline moves together; it holds only while the output word waits.
    assign advance    = !v3_reg || !out_stall;
    assign q_pop      = q_valid && !busy_reg;
    assign start_mul  = q_pop && q_item.is_mul;
    assign do_load    = q_pop && !q_item.is_mul;
    assign issue      = busy_reg && advance;
    assign issue_last = issue && (k_reg == last_k_reg);

    assign status.busy       = busy_reg;
    assign status.issue_last = issue_last;

    // Entry count is two to the qubit count, saturated at the store size.
    always_comb
    begin
        if (b_qubits >= BQ_W'(BIDX_W))
        begin
            last_k_cfg = BIDX_W'(MAX_B_ENTRIES - 1);
        end
        else
        begin
            last_k_cfg = BIDX_W'((BCNT_W'(1) << b_qubits) - BCNT_W'(1));
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        k_next      = k_reg;
        last_k_next = last_k_reg;
        if (start_mul)
        begin
            busy_next   = 1'b1;
            k_next      = '0;
            last_k_next = last_k_cfg;
        end
        else if (issue)
        begin
            if (issue_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            k_reg      <= '0;
            last_k_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            k_reg      <= k_next;
            last_k_reg <= last_k_next;
            if (advance)
            begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    // Store: one write port for loads, one registered read port for the sweep.
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            b_mem_re[q_item.idx] <= q_item.re;
            b_mem_im[q_item.idx] <= q_item.im;
        end
        if (issue)
        begin
            s1_b_re_reg <= b_mem_re[k_reg];
            s1_b_im_reg <= b_mem_im[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_mul)
        begin
            a_re_reg <= q_item.re;
            a_im_reg <= q_item.im;
        end
        if (advance)
        begin
            s1_a_re_reg <= a_re_reg;
            s1_a_im_reg <= a_im_reg;
            s1_idx_reg  <= k_reg;
            s1_last_reg <= (k_reg == last_k_reg);
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    ckp_cmul u_cmul (
        .clk  (clk),
        .en   (advance),
        .a_re (s1_a_re_reg),
        .a_im (s1_a_im_reg),
        .b_re (s1_b_re_reg),
        .b_im (s1_b_im_reg),
        .p_re (prod_re),
        .p_im (prod_im)
    );

    assign out_valid   = v3_reg;
    assign out_b_index = s3_idx_reg;
    assign last        = s3_last_reg;

endmodule

`default_nettype wire
